// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define LAV_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle
`define LAV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define LAV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lav_pkg.sv
package lav_pkg;

  localparam int VEC_FRAC_BITS = 14;
  localparam int NORM_SH       = 31 - VEC_FRAC_BITS;
  localparam int DIV_STEPS     = 63;
  localparam int SQRT_STEPS    = 32;
  localparam int NORM_PRE      = 5;
  localparam int NORM_POST     = 2;
  localparam int NORM_LAT      = NORM_PRE + DIV_STEPS + SQRT_STEPS + NORM_POST;
  localparam int CROSS_LAT     = 2;
  localparam int FRAME_LAT     = 6;

  typedef logic signed [15:0] vec_t;
  typedef logic signed [23:0] pos_t;
  typedef logic signed [31:0] trn_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  typedef struct packed {
    vec_t m00;
    vec_t m10;
    vec_t m20;
    vec_t m01;
    vec_t m11;
    vec_t m21;
    vec_t m02;
    vec_t m12;
    vec_t m22;
    trn_t tr_x;
    trn_t tr_y;
    trn_t tr_z;
  } res_t;

  function automatic logic [47:0] mag48(input logic signed [47:0] x);
    mag48 = x[47] ? 48'(-x) : 48'(x);
  endfunction

  // round half away from zero on a magnitude
  function automatic logic [47:0] rnd_vec(input logic [47:0] m);
    rnd_vec = (m + (48'd1 << (VEC_FRAC_BITS - 1))) >> VEC_FRAC_BITS;
  endfunction

  function automatic vec_t sat16(input logic neg, input logic [47:0] m);
    vec_t r;
    if (neg) begin
      if (m > 48'd32768) r = 16'sh8000;
      else r = 16'(48'd0 - m);
    end else if (m > 48'd32767) begin
      r = 16'sh7fff;
    end else begin
      r = 16'(m);
    end
    return r;
  endfunction

  function automatic trn_t sat32(input logic neg, input logic [47:0] m);
    trn_t r;
    if (neg) begin
      if (m > 48'h0000_8000_0000) r = 32'sh8000_0000;
      else r = 32'(48'd0 - m);
    end else if (m > 48'h0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = 32'(m);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/lav_cross.sv
module lav_cross (
  input  logic                clk,
  input  logic                rst,
  input  lav_pkg::pipe_ctl_t  ctl,
  input  lav_pkg::vec_t       f [3],
  input  lav_pkg::vec_t       u [3],
  input  lav_pkg::pos_t       e [3],
  output logic                vld,
  output logic signed [32:0]  fu [3],
  output lav_pkg::vec_t       fo [3],
  output lav_pkg::pos_t       eo [3]
);

  logic [lav_pkg::CROSS_LAT-1:0] vpipe;
  logic signed [31:0] p [6];
  lav_pkg::vec_t f1 [3];
  lav_pkg::pos_t e1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ctl.en) begin
      vpipe <= {vpipe[lav_pkg::CROSS_LAT-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p[0] <= f[1] * u[2];
      p[1] <= f[2] * u[1];
      p[2] <= f[2] * u[0];
      p[3] <= f[0] * u[2];
      p[4] <= f[0] * u[1];
      p[5] <= f[1] * u[0];
      f1   <= f;
      e1   <= e;
      fu[0] <= 33'(p[0]) - 33'(p[1]);
      fu[1] <= 33'(p[2]) - 33'(p[3]);
      fu[2] <= 33'(p[4]) - 33'(p[5]);
      fo    <= f1;
      eo    <= e1;
    end
  end

  assign vld = vpipe[lav_pkg::CROSS_LAT-1];

endmodule

// File: rtl/core/lav_norm.sv
module lav_norm (
  input  logic                clk,
  input  logic                rst,
  input  lav_pkg::pipe_ctl_t  ctl,
  input  logic signed [32:0]  c [3],
  output logic                vld,
  output lav_pkg::vec_t       o [3]
);

  localparam int DS = lav_pkg::DIV_STEPS;
  localparam int SS = lav_pkg::SQRT_STEPS;
  localparam int NL = lav_pkg::NORM_LAT;

  typedef struct packed {
    logic [2:0][14:0] m;
    logic [2:0]       neg;
    logic             zero;
  } pay_t;

  logic [NL-1:0] vpipe;

  logic [31:0] a_m [3];
  logic [2:0]  a_neg;
  logic [31:0] orv;
  logic [4:0]  s_next;
  logic [31:0] b_m [3];
  logic [2:0]  b_neg;
  logic [4:0]  b_s;
  pay_t        c_pay;
  pay_t        d_pay;
  logic [29:0] d_sq [3];
  pay_t        e_pay;
  logic [31:0] e_n2;

  logic [31:0] dv_rem [1:DS];
  logic [62:0] dv_q   [1:DS];
  logic [31:0] dv_n2  [1:DS];
  pay_t        dv_pay [1:DS];

  logic [63:0] sq_n   [1:SS];
  logic [63:0] sq_res [1:SS];
  pay_t        sq_pay [1:SS];

  logic [46:0] pp [3];
  pay_t        p_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ctl.en) begin
      vpipe <= {vpipe[NL-2:0], ctl.vld};
    end
  end

  // common shift so that every magnitude fits in 15 bits
  assign orv = a_m[0] | a_m[1] | a_m[2];

  always_comb begin
    s_next = '0;
    for (int p = 15; p < 32; p++) begin
      if (orv[p]) s_next = 5'(p - 14);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= c[i][32];
        a_m[i]   <= c[i][32] ? 32'(-c[i]) : 32'(c[i]);
      end
      b_m   <= a_m;
      b_neg <= a_neg;
      b_s   <= s_next;
      for (int i = 0; i < 3; i++) begin
        c_pay.m[i] <= 15'(b_m[i] >> b_s);
      end
      c_pay.neg  <= b_neg;
      c_pay.zero <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= 30'(c_pay.m[i]) * 30'(c_pay.m[i]);
      end
      d_pay <= c_pay;
      e_n2  <= 32'(d_sq[0]) + 32'(d_sq[1]) + 32'(d_sq[2]);
      e_pay.m    <= d_pay.m;
      e_pay.neg  <= d_pay.neg;
      e_pay.zero <= (d_sq[0] == '0) && (d_sq[1] == '0) && (d_sq[2] == '0);
    end
  end

  // restoring division of 2^62 by n2, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [32:0] t;
    logic [31:0] n2_cur;
    logic [61:0] q_cur;
    pay_t        pay_cur;
    logic        ge;
    if (k == 0) begin : g_first
      assign t       = 33'd1;
      assign n2_cur  = e_n2;
      assign q_cur   = '0;
      assign pay_cur = e_pay;
    end else begin : g_rest
      assign t       = {dv_rem[k], 1'b0};
      assign n2_cur  = dv_n2[k];
      assign q_cur   = dv_q[k][61:0];
      assign pay_cur = dv_pay[k];
    end
    assign ge = t >= {1'b0, n2_cur};
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        dv_rem[k+1] <= ge ? 32'(t - {1'b0, n2_cur}) : t[31:0];
        dv_q[k+1]   <= {q_cur, ge};
        dv_n2[k+1]  <= n2_cur;
        dv_pay[k+1] <= pay_cur;
      end
    end
  end

  // floor square root of the quotient, one result bit per stage
  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SS - 1) - 2 * j);
    logic [63:0] n_cur;
    logic [63:0] r_cur;
    logic [63:0] tsum;
    pay_t        pay_cur;
    logic        ge;
    if (j == 0) begin : g_first
      assign n_cur   = {1'b0, dv_q[DS]};
      assign r_cur   = '0;
      assign pay_cur = dv_pay[DS];
    end else begin : g_rest
      assign n_cur   = sq_n[j];
      assign r_cur   = sq_res[j];
      assign pay_cur = sq_pay[j];
    end
    assign tsum = r_cur + BIT;
    assign ge   = n_cur >= tsum;
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        sq_n[j+1]   <= ge ? n_cur - tsum : n_cur;
        sq_res[j+1] <= ge ? (r_cur >> 1) + BIT : r_cur >> 1;
        sq_pay[j+1] <= pay_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= 47'(sq_pay[SS].m[i]) * 47'(sq_res[SS][31:0]);
      end
      p_pay <= sq_pay[SS];
      for (int i = 0; i < 3; i++) begin
        if (p_pay.zero) begin
          o[i] <= '0;
        end else begin
          o[i] <= lav_pkg::sat16(p_pay.neg[i],
                    (48'(pp[i]) + (48'd1 << (lav_pkg::NORM_SH - 1))) >> lav_pkg::NORM_SH);
        end
      end
    end
  end

  assign vld = vpipe[NL-1];

endmodule

// File: rtl/core/lav_frame.sv
module lav_frame (
  input  logic                clk,
  input  logic                rst,
  input  lav_pkg::pipe_ctl_t  ctl,
  input  lav_pkg::vec_t       rc [3],
  input  lav_pkg::vec_t       fn [3],
  input  lav_pkg::pos_t       e [3],
  output logic                vld,
  output lav_pkg::res_t       res
);

  localparam int FL = lav_pkg::FRAME_LAT;

  logic [FL-1:0] vpipe;

  logic signed [31:0] pu [6];
  logic signed [39:0] pr [3];
  logic signed [39:0] pf [3];
  lav_pkg::vec_t      rc1 [3];
  lav_pkg::vec_t      fn1 [3];
  lav_pkg::pos_t      e1 [3];

  logic signed [32:0] uc [3];
  logic signed [41:0] dr;
  logic signed [41:0] df;
  lav_pkg::vec_t      rc2 [3];
  lav_pkg::vec_t      fn2 [3];
  lav_pkg::pos_t      e2 [3];

  lav_pkg::res_t      res3;
  lav_pkg::pos_t      e3 [3];
  lav_pkg::res_t      res4;
  logic signed [39:0] pt [3];
  lav_pkg::res_t      res5;
  logic signed [41:0] dt;
  lav_pkg::res_t      res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ctl.en) begin
      vpipe <= {vpipe[FL-2:0], ctl.vld};
    end
  end

  // last stage fills in the up translation
  always_comb begin
    res_next      = res5;
    res_next.tr_y = lav_pkg::sat32(!dt[41], lav_pkg::rnd_vec(lav_pkg::mag48(48'(dt))));
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // true up = right x forward, and the dot products with eye
      pu[0] <= rc[1] * fn[2];
      pu[1] <= rc[2] * fn[1];
      pu[2] <= rc[2] * fn[0];
      pu[3] <= rc[0] * fn[2];
      pu[4] <= rc[0] * fn[1];
      pu[5] <= rc[1] * fn[0];
      for (int i = 0; i < 3; i++) begin
        pr[i] <= 40'(rc[i]) * 40'(e[i]);
        pf[i] <= 40'(fn[i]) * 40'(e[i]);
      end
      rc1 <= rc;
      fn1 <= fn;
      e1  <= e;

      uc[0] <= 33'(pu[0]) - 33'(pu[1]);
      uc[1] <= 33'(pu[2]) - 33'(pu[3]);
      uc[2] <= 33'(pu[4]) - 33'(pu[5]);
      dr    <= 42'(pr[0]) + 42'(pr[1]) + 42'(pr[2]);
      df    <= 42'(pf[0]) + 42'(pf[1]) + 42'(pf[2]);
      rc2   <= rc1;
      fn2   <= fn1;
      e2    <= e1;

      res3.m00  <= rc2[0];
      res3.m10  <= rc2[1];
      res3.m20  <= rc2[2];
      res3.m01  <= lav_pkg::sat16(uc[0][32], lav_pkg::rnd_vec(lav_pkg::mag48(48'(uc[0]))));
      res3.m11  <= lav_pkg::sat16(uc[1][32], lav_pkg::rnd_vec(lav_pkg::mag48(48'(uc[1]))));
      res3.m21  <= lav_pkg::sat16(uc[2][32], lav_pkg::rnd_vec(lav_pkg::mag48(48'(uc[2]))));
      res3.m02  <= lav_pkg::sat16(!fn2[0][15], lav_pkg::mag48(48'(fn2[0])));
      res3.m12  <= lav_pkg::sat16(!fn2[1][15], lav_pkg::mag48(48'(fn2[1])));
      res3.m22  <= lav_pkg::sat16(!fn2[2][15], lav_pkg::mag48(48'(fn2[2])));
      res3.tr_x <= lav_pkg::sat32(!dr[41], lav_pkg::rnd_vec(lav_pkg::mag48(48'(dr))));
      res3.tr_y <= '0;
      res3.tr_z <= lav_pkg::sat32(df[41], lav_pkg::rnd_vec(lav_pkg::mag48(48'(df))));
      e3        <= e2;

      pt[0] <= 40'(res3.m01) * 40'(e3[0]);
      pt[1] <= 40'(res3.m11) * 40'(e3[1]);
      pt[2] <= 40'(res3.m21) * 40'(e3[2]);
      res4  <= res3;

      dt    <= 42'(pt[0]) + 42'(pt[1]) + 42'(pt[2]);
      res5  <= res4;

      res   <= res_next;
    end
  end

  assign vld = vpipe[FL-1];

endmodule

// File: rtl/core/look_at_view_matrix_top.sv
// throughput: one word per cycle while the output buffer has room; each normalizer
// is a 63-stage divider followed by a 32-stage square root, fully pipelined, so
// nothing iterates
// a two-word output buffer lets the pipeline run while a result waits
// reset clears the valid bits and the output buffer; no clearing pass
`include "assert_macros.svh"

module look_at_view_matrix_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lav_pkg::vec_t        fwd_x,
  input  lav_pkg::vec_t        fwd_y,
  input  lav_pkg::vec_t        fwd_z,
  input  lav_pkg::vec_t        upv_x,
  input  lav_pkg::vec_t        upv_y,
  input  lav_pkg::vec_t        upv_z,
  input  lav_pkg::pos_t        eye_x,
  input  lav_pkg::pos_t        eye_y,
  input  lav_pkg::pos_t        eye_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lav_pkg::vec_t        m00,
  output lav_pkg::vec_t        m10,
  output lav_pkg::vec_t        m20,
  output lav_pkg::vec_t        m01,
  output lav_pkg::vec_t        m11,
  output lav_pkg::vec_t        m21,
  output lav_pkg::vec_t        m02,
  output lav_pkg::vec_t        m12,
  output lav_pkg::vec_t        m22,
  output lav_pkg::trn_t        tr_x,
  output lav_pkg::trn_t        tr_y,
  output lav_pkg::trn_t        tr_z
);

  localparam int NL = lav_pkg::NORM_LAT;

  logic               adv;
  lav_pkg::pipe_ctl_t cx_ctl;
  lav_pkg::pipe_ctl_t nm_ctl;
  lav_pkg::pipe_ctl_t fr_ctl;

  lav_pkg::vec_t      in_f [3];
  lav_pkg::vec_t      in_u [3];
  lav_pkg::pos_t      in_e [3];

  logic               cx_vld;
  logic signed [32:0] cx_fu [3];
  lav_pkg::vec_t      cx_f [3];
  lav_pkg::pos_t      cx_e [3];
  logic signed [32:0] cx_fs [3];

  logic               nf_vld;
  logic               nr_vld;
  lav_pkg::vec_t      fn [3];
  lav_pkg::vec_t      rc [3];
  lav_pkg::pos_t      eye_d [NL][3];

  logic               fr_vld;
  lav_pkg::res_t      fr_res;

  lav_pkg::res_t      buf_mem [2];
  logic               wp;
  logic               rp;
  logic [1:0]         cnt;
  logic               push;
  logic               pop;
  lav_pkg::res_t      head;

  // the whole pipeline moves whenever the output buffer has room
  assign adv      = (cnt != 2'd2);
  assign in_ready = adv;

  assign cx_ctl = '{en: adv, vld: in_valid};
  assign nm_ctl = '{en: adv, vld: cx_vld};
  assign fr_ctl = '{en: adv, vld: nf_vld};

  assign in_f = '{fwd_x, fwd_y, fwd_z};
  assign in_u = '{upv_x, upv_y, upv_z};
  assign in_e = '{eye_x, eye_y, eye_z};

  lav_cross u_cross (
    .clk (clk),
    .rst (rst),
    .ctl (cx_ctl),
    .f   (in_f),
    .u   (in_u),
    .e   (in_e),
    .vld (cx_vld),
    .fu  (cx_fu),
    .fo  (cx_f),
    .eo  (cx_e)
  );

  for (genvar i = 0; i < 3; i++) begin : g_fs
    assign cx_fs[i] = 33'(cx_f[i]);
  end

  lav_norm u_norm_fwd (
    .clk (clk),
    .rst (rst),
    .ctl (nm_ctl),
    .c   (cx_fs),
    .vld (nf_vld),
    .o   (fn)
  );

  lav_norm u_norm_right (
    .clk (clk),
    .rst (rst),
    .ctl (nm_ctl),
    .c   (cx_fu),
    .vld (nr_vld),
    .o   (rc)
  );

  // eye rides alongside the normalizers
  always_ff @(posedge clk) begin
    if (adv) begin
      eye_d[0] <= cx_e;
      for (int k = 1; k < NL; k++) begin
        eye_d[k] <= eye_d[k-1];
      end
    end
  end

  lav_frame u_frame (
    .clk (clk),
    .rst (rst),
    .ctl (fr_ctl),
    .rc  (rc),
    .fn  (fn),
    .e   (eye_d[NL-1]),
    .vld (fr_vld),
    .res (fr_res)
  );

  assign push = fr_vld && adv;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_mem[wp] <= fr_res;
  end

  assign head      = buf_mem[rp];
  assign out_valid = (cnt != 2'd0);
  assign m00  = head.m00;
  assign m10  = head.m10;
  assign m20  = head.m20;
  assign m01  = head.m01;
  assign m11  = head.m11;
  assign m21  = head.m21;
  assign m02  = head.m02;
  assign m12  = head.m12;
  assign m22  = head.m22;
  assign tr_x = head.tr_x;
  assign tr_y = head.tr_y;
  assign tr_z = head.tr_z;

  `LAV_ASSERT_NOW(a_cnt_range, cnt != 2'd3, "output buffer count out of range")
  `LAV_ASSERT_NOW(a_lanes_aligned, nf_vld == nr_vld, "normalizer lanes out of step")
  `LAV_ASSERT_NXT(a_stall_holds, !adv && fr_vld, fr_vld && $stable(fr_res), "stalled word lost")
  `LAV_ASSERT_NXT(a_cnt_grows, push && !pop, cnt == $past(cnt) + 2'd1, "buffer count mismatch")

endmodule
